FILE: sv/disa_pkg.sv
// Shared types and constants for the dual instruction-set classifier.
package disa_pkg;

  localparam int unsigned ClassW = 6;

  localparam logic [7:0] CbSave = 8'h01;
  localparam logic [7:0] CbWb   = 8'h02;
  localparam logic [7:0] CbUp   = 8'h04;
  localparam logic [7:0] CbPre  = 8'h08;
  localparam logic [7:0] CbType = 8'h10;
  localparam logic [7:0] CbLink = 8'h20;
  localparam logic [7:0] CbAcc  = 8'h40;
  localparam logic [7:0] CbSign = 8'h80;

  typedef enum logic [ClassW-1:0] {
    A_BRANCH = 6'd0, A_BX = 6'd1, A_DATA_IMM = 6'd2, A_DATA_ISH = 6'd3,
    A_DATA_RSH = 6'd4, A_LDS_IMM = 6'd5, A_LDS_REG = 6'd6, A_SWAP = 6'd7,
    A_HALF_IMM = 6'd8, A_HALF_REG = 6'd9, A_SINGLE_IMM = 6'd10, A_BLOCK = 6'd11,
    A_SINGLE_REG = 6'd12, A_MRS = 6'd13, A_MSR_IMM = 6'd14, A_MSR_REG = 6'd15,
    A_MUL = 6'd16, A_MULL = 6'd17, A_SWI = 6'd18, A_UNDEF = 6'd19,
    T_ALU = 6'd20, T_ALU_HI = 6'd21, T_ADD_PCSP = 6'd22, T_ADDSUB_IMM = 6'd23,
    T_ADDSUB_REG = 6'd24, T_ADJ_SP = 6'd25, T_BX = 6'd26, T_BL_HI = 6'd27,
    T_BL_LO = 6'd28, T_BRANCH = 6'd29, T_BCOND = 6'd30, T_IMM8 = 6'd31,
    T_PC_LOAD = 6'd32, T_BYTE_IMM = 6'd33, T_HALF_IMM = 6'd34, T_BLOCK = 6'd35,
    T_REG_OFF = 6'd36, T_SP_REL = 6'd37, T_WORD_IMM = 6'd38, T_SHIFT_IMM = 6'd39,
    T_SWI = 6'd40, T_PUSH_POP = 6'd41, T_UNDEF = 6'd42
  } class_t;

  // One classified instruction as it travels from the front part to the back.
  typedef struct packed {
    logic [ClassW-1:0] instr_class;
    logic              executes;
    logic [3:0]        reg_dest;
    logic [3:0]        reg_base;
    logic [3:0]        reg_operand;
    logic [3:0]        reg_shift;
    logic [23:0]       imm_value;
    logic [4:0]        shift_amount;
    logic [1:0]        shift_kind;
    logic [3:0]        operation;
    logic [7:0]        control_bits;
  } decoded_t;

  function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
    logic n, z, cy, v, r;
    n = f[3]; z = f[2]; cy = f[1]; v = f[0];
    unique case (c)
      4'd0: r = z;
      4'd1: r = !z;
      4'd2: r = cy;
      4'd3: r = !cy;
      4'd4: r = n;
      4'd5: r = !n;
      4'd6: r = v;
      4'd7: r = !v;
      4'd8: r = cy && !z;
      4'd9: r = !cy || z;
      4'd10: r = n == v;
      4'd11: r = n != v;
      4'd12: r = !z && (n == v);
      4'd13: r = z || (n != v);
      4'd14: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/disa_front.sv
// Front part: accepts instructions and classifies them into a registered stage.
module disa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_instr_word,
  input  logic                 in_mode,
  input  logic [3:0]           in_flags_nzcv,
  output logic                 dec_valid,
  input  logic                 dec_stall,
  output disa_pkg::decoded_t   dec_data
);

  logic               valid_r;
  disa_pkg::decoded_t data_r;
  disa_pkg::decoded_t d32;
  disa_pkg::decoded_t d16;

  always_comb begin
    logic [31:0] w;
    logic [7:0]  hi;
    logic [3:0]  lo;
    logic        cmp_nos;
    logic [7:0]  save;
    logic [7:0]  mctl;
    w = in_instr_word;
    hi = w[27:20];
    lo = w[7:4];
    cmp_nos = (hi & 8'h19) == 8'h10;
    save = w[20] ? disa_pkg::CbSave : 8'h00;
    mctl = (w[21] ? disa_pkg::CbWb : 8'h00) | (w[23] ? disa_pkg::CbUp : 8'h00) |
           (w[24] ? disa_pkg::CbPre : 8'h00);
    d32 = '0;
    d32.instr_class = disa_pkg::A_UNDEF;
    unique case (w[27:25])
      3'd0: begin
        if (!lo[0] || !lo[3]) begin
          if (cmp_nos) begin
            if (lo == 4'd0) begin
              d32.control_bits = w[22] ? disa_pkg::CbType : 8'h00;
              if (w[21]) begin
                d32.instr_class = disa_pkg::A_MSR_REG;
                d32.reg_operand = w[3:0];
                d32.operation = w[19:16];
              end else begin
                d32.instr_class = disa_pkg::A_MRS;
                d32.reg_dest = w[15:12];
              end
            end else if (hi == 8'h12 && lo == 4'd1) begin
              d32.instr_class = disa_pkg::A_BX;
              d32.reg_operand = w[3:0];
            end
          end else begin
            d32.reg_operand = w[3:0];
            d32.shift_kind = w[6:5];
            d32.reg_dest = w[15:12];
            d32.reg_base = w[19:16];
            d32.operation = w[24:21];
            d32.control_bits = save;
            if (!lo[0]) begin
              d32.instr_class = disa_pkg::A_DATA_ISH;
              d32.shift_amount = w[11:7];
            end else begin
              d32.instr_class = disa_pkg::A_DATA_RSH;
              d32.reg_shift = w[11:8];
            end
          end
        end else begin
          unique case (lo[2:1])
            2'd0: begin
              if ((hi & 8'hfc) == 8'h00) begin
                d32.instr_class = disa_pkg::A_MUL;
                d32.reg_operand = w[3:0];
                d32.reg_shift = w[11:8];
                d32.reg_base = w[15:12];
                d32.reg_dest = w[19:16];
                d32.control_bits = save | (w[21] ? disa_pkg::CbAcc : 8'h00);
              end else if ((hi & 8'hf8) == 8'h08) begin
                d32.instr_class = disa_pkg::A_MULL;
                d32.reg_operand = w[3:0];
                d32.reg_shift = w[11:8];
                d32.reg_dest = w[15:12];
                d32.reg_base = w[19:16];
                d32.control_bits = save | (w[21] ? disa_pkg::CbAcc : 8'h00) |
                                   (w[22] ? disa_pkg::CbSign : 8'h00);
              end else if ((hi & 8'hfb) == 8'h10) begin
                d32.instr_class = disa_pkg::A_SWAP;
                d32.reg_operand = w[3:0];
                d32.reg_dest = w[15:12];
                d32.reg_base = w[19:16];
                d32.control_bits = w[22] ? disa_pkg::CbType : 8'h00;
              end
            end
            2'd1: begin
              d32.reg_dest = w[15:12];
              d32.reg_base = w[19:16];
              d32.operation = {3'd0, w[20]};
              d32.control_bits = mctl;
              if (w[22]) begin
                d32.instr_class = disa_pkg::A_HALF_IMM;
                d32.imm_value = {16'd0, w[11:8], w[3:0]};
              end else begin
                d32.instr_class = disa_pkg::A_HALF_REG;
                d32.reg_operand = w[3:0];
              end
            end
            default: begin
              if (w[20]) begin
                d32.reg_dest = w[15:12];
                d32.reg_base = w[19:16];
                d32.control_bits = mctl | (w[5] ? disa_pkg::CbType : 8'h00);
                if (w[22]) begin
                  d32.instr_class = disa_pkg::A_LDS_IMM;
                  d32.imm_value = {16'd0, w[11:8], w[3:0]};
                end else begin
                  d32.instr_class = disa_pkg::A_LDS_REG;
                  d32.reg_operand = w[3:0];
                end
              end
            end
          endcase
        end
      end
      3'd1: begin
        if (cmp_nos) begin
          if (w[21]) begin
            d32.instr_class = disa_pkg::A_MSR_IMM;
            d32.imm_value = {16'd0, w[7:0]};
            d32.shift_amount = {1'b0, w[11:8]};
            d32.operation = w[19:16];
            d32.control_bits = w[22] ? disa_pkg::CbType : 8'h00;
          end
        end else begin
          d32.instr_class = disa_pkg::A_DATA_IMM;
          d32.imm_value = {16'd0, w[7:0]};
          d32.shift_amount = {1'b0, w[11:8]};
          d32.reg_dest = w[15:12];
          d32.reg_base = w[19:16];
          d32.operation = w[24:21];
          d32.control_bits = save;
        end
      end
      3'd2: begin
        d32.instr_class = disa_pkg::A_SINGLE_IMM;
        d32.imm_value = {12'd0, w[11:0]};
        d32.reg_dest = w[15:12];
        d32.reg_base = w[19:16];
        d32.operation = {3'd0, w[20]};
        d32.control_bits = mctl | (w[22] ? disa_pkg::CbType : 8'h00);
      end
      3'd3: begin
        if (!lo[0]) begin
          d32.instr_class = disa_pkg::A_SINGLE_REG;
          d32.reg_operand = w[3:0];
          d32.shift_kind = w[6:5];
          d32.shift_amount = w[11:7];
          d32.reg_dest = w[15:12];
          d32.reg_base = w[19:16];
          d32.operation = {3'd0, w[20]};
          d32.control_bits = mctl | (w[22] ? disa_pkg::CbType : 8'h00);
        end
      end
      3'd4: begin
        d32.instr_class = disa_pkg::A_BLOCK;
        d32.imm_value = {8'd0, w[15:0]};
        d32.reg_base = w[19:16];
        d32.operation = {3'd0, w[20]};
        d32.control_bits = mctl | (w[22] ? disa_pkg::CbType : 8'h00);
      end
      3'd5: begin
        d32.instr_class = disa_pkg::A_BRANCH;
        d32.imm_value = w[23:0];
        d32.control_bits = w[24] ? disa_pkg::CbLink : 8'h00;
      end
      3'd6: begin
      end
      default: begin
        if (w[24]) begin
          d32.instr_class = disa_pkg::A_SWI;
          d32.imm_value = w[23:0];
        end
      end
    endcase
    d32.executes = disa_pkg::cond_pass(w[31:28], in_flags_nzcv);
  end

  always_comb begin
    logic [15:0] h;
    h = in_instr_word[15:0];
    d16 = '0;
    d16.instr_class = disa_pkg::T_UNDEF;
    unique case (h[15:13])
      3'd0: begin
        if (h[12:11] == 2'd3) begin
          d16.reg_dest = {1'b0, h[2:0]};
          d16.reg_base = {1'b0, h[5:3]};
          d16.operation = {3'd0, h[9]};
          if (h[10]) begin
            d16.instr_class = disa_pkg::T_ADDSUB_IMM;
            d16.imm_value = {21'd0, h[8:6]};
          end else begin
            d16.instr_class = disa_pkg::T_ADDSUB_REG;
            d16.reg_operand = {1'b0, h[8:6]};
          end
        end else begin
          d16.instr_class = disa_pkg::T_SHIFT_IMM;
          d16.reg_dest = {1'b0, h[2:0]};
          d16.reg_operand = {1'b0, h[5:3]};
          d16.shift_amount = h[10:6];
          d16.shift_kind = h[12:11];
        end
      end
      3'd1: begin
        d16.instr_class = disa_pkg::T_IMM8;
        d16.imm_value = {16'd0, h[7:0]};
        d16.reg_dest = {1'b0, h[10:8]};
        d16.operation = {2'd0, h[12:11]};
      end
      3'd2: begin
        if (h[12]) begin
          d16.instr_class = disa_pkg::T_REG_OFF;
          d16.reg_dest = {1'b0, h[2:0]};
          d16.reg_base = {1'b0, h[5:3]};
          d16.reg_operand = {1'b0, h[8:6]};
          d16.operation = {1'b0, h[11:9]};
        end else begin
          unique case (h[11:10])
            2'd0: begin
              d16.instr_class = disa_pkg::T_ALU;
              d16.reg_dest = {1'b0, h[2:0]};
              d16.reg_operand = {1'b0, h[5:3]};
              d16.operation = h[9:6];
            end
            2'd1: begin
              if (h[9:8] == 2'd3) begin
                if (!h[7]) begin
                  d16.instr_class = disa_pkg::T_BX;
                  d16.reg_operand = h[6:3];
                end
              end else begin
                d16.instr_class = disa_pkg::T_ALU_HI;
                d16.reg_dest = {h[7], h[2:0]};
                d16.reg_operand = h[6:3];
                d16.operation = {2'd0, h[9:8]};
              end
            end
            default: begin
              d16.instr_class = disa_pkg::T_PC_LOAD;
              d16.imm_value = {16'd0, h[7:0]};
              d16.reg_dest = {1'b0, h[10:8]};
            end
          endcase
        end
      end
      3'd3, 3'd4: begin
        if (h[15:13] == 3'd4 && h[12]) begin
          d16.instr_class = disa_pkg::T_SP_REL;
          d16.imm_value = {16'd0, h[7:0]};
          d16.reg_dest = {1'b0, h[10:8]};
          d16.operation = {3'd0, h[11]};
        end else begin
          if (h[15:13] == 3'd4) d16.instr_class = disa_pkg::T_HALF_IMM;
          else if (h[12]) d16.instr_class = disa_pkg::T_BYTE_IMM;
          else d16.instr_class = disa_pkg::T_WORD_IMM;
          d16.reg_dest = {1'b0, h[2:0]};
          d16.reg_base = {1'b0, h[5:3]};
          d16.imm_value = {19'd0, h[10:6]};
          d16.operation = {3'd0, h[11]};
        end
      end
      3'd5: begin
        if (!h[12]) begin
          d16.instr_class = disa_pkg::T_ADD_PCSP;
          d16.imm_value = {16'd0, h[7:0]};
          d16.reg_dest = {1'b0, h[10:8]};
          d16.operation = {3'd0, h[11]};
        end else if (h[11:8] == 4'd0) begin
          d16.instr_class = disa_pkg::T_ADJ_SP;
          d16.imm_value = {17'd0, h[6:0]};
          d16.operation = {3'd0, h[7]};
        end else if (h[10:9] == 2'd2) begin
          d16.instr_class = disa_pkg::T_PUSH_POP;
          d16.imm_value = {16'd0, h[7:0]};
          d16.control_bits = h[8] ? disa_pkg::CbLink : 8'h00;
          d16.operation = {3'd0, h[11]};
        end
      end
      3'd6: begin
        if (!h[12]) begin
          d16.instr_class = disa_pkg::T_BLOCK;
          d16.imm_value = {16'd0, h[7:0]};
          d16.reg_base = {1'b0, h[10:8]};
          d16.operation = {3'd0, h[11]};
        end else if (h[11:8] == 4'hf) begin
          d16.instr_class = disa_pkg::T_SWI;
          d16.imm_value = {16'd0, h[7:0]};
        end else begin
          d16.instr_class = disa_pkg::T_BCOND;
          d16.imm_value = {16'd0, h[7:0]};
          d16.operation = h[11:8];
        end
      end
      default: begin
        unique case (h[12:11])
          2'd0: begin
            d16.instr_class = disa_pkg::T_BRANCH;
            d16.imm_value = {13'd0, h[10:0]};
          end
          2'd1: begin
          end
          2'd2: begin
            d16.instr_class = disa_pkg::T_BL_HI;
            d16.imm_value = {13'd0, h[10:0]};
          end
          default: begin
            d16.instr_class = disa_pkg::T_BL_LO;
            d16.imm_value = {13'd0, h[10:0]};
          end
        endcase
      end
    endcase
    d16.executes = 1'b1;
  end

  // The stage refills whenever it is empty or its contents move on.
  assign in_stall = valid_r && dec_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      data_r <= in_mode ? d16 : d32;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

FILE: sv/disa_back.sv
// Back part: a two-entry queue that holds classified instructions for the output.
module disa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 dec_valid,
  output logic                 dec_stall,
  input  disa_pkg::decoded_t   dec_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output disa_pkg::decoded_t   out_data
);

  disa_pkg::decoded_t mem_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               push;
  logic               pop;

  assign dec_stall = count_r == 2'd2;
  assign push = dec_valid && !dec_stall;
  assign pop  = out_valid && !out_stall;
  assign out_valid = count_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_ptr_r] <= dec_data;
  end

endmodule

FILE: sv/dual_isa_instruction_classifier.sv
// Top level of the dual instruction-set classifier.
// One instruction is taken per cycle unless in_stall is high; it passes first through the
// registered decode stage of the front part, then the two-entry queue of the back part, whose
// head drives the output ports. Throughput is one transfer per cycle in each direction when
// not stalled; the queue absorbs short output stalls while decode keeps going.
module dual_isa_instruction_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr_word,
  input  logic        in_mode,
  input  logic [3:0]  in_flags_nzcv,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_instr_class,
  output logic        out_executes,
  output logic [3:0]  out_reg_dest,
  output logic [3:0]  out_reg_base,
  output logic [3:0]  out_reg_operand,
  output logic [3:0]  out_reg_shift,
  output logic [23:0] out_imm_value,
  output logic [4:0]  out_shift_amount,
  output logic [1:0]  out_shift_kind,
  output logic [3:0]  out_operation,
  output logic [7:0]  out_control_bits
);

  logic               dec_valid;
  logic               dec_stall;
  disa_pkg::decoded_t dec_data;
  disa_pkg::decoded_t out_data;

  disa_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_instr_word, .in_mode, .in_flags_nzcv,
    .dec_valid, .dec_stall, .dec_data
  );

  disa_back u_back (
    .clk, .rst_n, .dec_valid, .dec_stall, .dec_data, .out_valid, .out_stall, .out_data
  );

  assign out_instr_class  = out_data.instr_class;
  assign out_executes     = out_data.executes;
  assign out_reg_dest     = out_data.reg_dest;
  assign out_reg_base     = out_data.reg_base;
  assign out_reg_operand  = out_data.reg_operand;
  assign out_reg_shift    = out_data.reg_shift;
  assign out_imm_value    = out_data.imm_value;
  assign out_shift_amount = out_data.shift_amount;
  assign out_shift_kind   = out_data.shift_kind;
  assign out_operation    = out_data.operation;
  assign out_control_bits = out_data.control_bits;

`ifndef ASSERT_OFF
  // A full queue must hold the front stage, so the front also stalls its input.
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_valid && dec_stall) |-> in_stall)
    else $error("input taken while decode stage blocked");

  // The 16-bit set always executes.
  a_thumb_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_instr_class >= disa_pkg::T_ALU) |-> out_executes)
    else $error("16-bit class not executing");

  // Class codes never exceed the last defined class.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_instr_class <= disa_pkg::T_UNDEF))
    else $error("class code out of range");
`endif

endmodule
